>>> sv/ising_pkg.sv
// Package: shared constants and types for the Ising spin update block.
package ising_pkg;

   localparam int SIDE_BITS = 4;
   localparam int SITE_BITS = 2 * SIDE_BITS;
   localparam int SITES     = 1 << SITE_BITS;

   localparam int LEVEL_W  = 17;
   localparam int FRAC_W   = 16;
   localparam int ENERGY_W = 11;
   localparam int MAG_W    = 10;

   // Count of lattice reads per item: the site itself and its four neighbors.
   localparam int READ_COUNT = 5;
   localparam int STEP_W     = 3;

   localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITES);
   localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITES);
   localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = LEVEL_W'(65536);

   // Register indexes on the csr port.
   localparam logic CSR_LEVEL_FOUR  = 1'b0;
   localparam logic CSR_LEVEL_EIGHT = 1'b1;

   // Item kinds carried in req_tuser.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TRIAL = 1'b1;

   // Access to the lattice store: one port, read or write each cycle.
   typedef struct packed {
      logic                 we;
      logic [SITE_BITS-1:0] addr;
      logic                 wdata;
   } lat_req_type;

endpackage

>>> sv/ising_lattice.sv
// Lattice spin store: single-port memory with reset-to-up valid bits.
module ising_lattice (
   input  logic                     clock,
   input  logic                     reset,
   input  ising_pkg::lat_req_type   lat_req,
   output logic                     rd_spin
);

   logic                         lattice_ff [ising_pkg::SITES];
   logic [ising_pkg::SITES-1:0]  valid_ff;
   logic                         rd_data_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (lat_req.we) begin
         lattice_ff[lat_req.addr] <= lat_req.wdata;
      end
      rd_data_ff <= lattice_ff[lat_req.addr];
   end

   // never-written sites read as spin up
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (lat_req.we) begin
            valid_ff[lat_req.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[lat_req.addr];
      end
   end

   assign rd_spin = rd_valid_ff ? rd_data_ff : 1'b1;

endmodule

>>> sv/ising_metropolis_spin_update.sv
// Top level: 2D Ising lattice with Metropolis trials and running totals.
//
// A 16x16 lattice of spins (periodic wrap) with running energy and
// magnetization. Each req item either writes one spin (tuser = 0) or runs a
// Metropolis trial at one site (tuser = 1); each returns exactly one rsp item
// with the flip flag, the site's spin afterwards and both totals. Each item
// makes five reads of the single-port lattice memory (site plus four
// neighbors, one per cycle, data in the cycle after each address), then an
// evaluate/write-back state and a state that loads the response register,
// before the next item is accepted. The response register lets it start while
// an earlier result waits; a new result is held back until that one leaves.
// The lattice resets to all spins up, energy -512, magnetization 256;
// both acceptance levels reset to 65536 (always accept). Write the csr
// port only while the block is idle.
module ising_metropolis_spin_update (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // row[3:0], col[7:4], spin_in[8], rand_fraction[24:9]
   input  logic        req_tuser,  // cmd: 0 write spin, 1 trial
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // flipped[0], spin_out[1], energy[12:2], magnetization[22:13]
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type                              state_ff, state_in;
   logic [ising_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [2:0]                             agree_ff, agree_in;
   logic                                   center_ff, center_in;

   // latched item fields
   logic                                   cmd_ff;
   logic [ising_pkg::SIDE_BITS-1:0]        row_ff, col_ff;
   logic                                   spin_in_ff;
   logic [ising_pkg::FRAC_W-1:0]           frac_ff;

   logic [ising_pkg::LEVEL_W-1:0]          level_four_ff, level_eight_ff;
   logic [ising_pkg::ENERGY_W-1:0]         energy_ff, energy_in;
   logic [ising_pkg::MAG_W-1:0]            mag_ff, mag_in;

   logic                                   flip_ff, flip_in;
   logic                                   spin_new_ff, spin_new_in;

   logic                                   rsp_valid_ff;
   logic [23:0]                            rsp_data_ff;

   ising_pkg::lat_req_type                 lat_req;
   logic                                   rd_spin;

   logic [ising_pkg::SIDE_BITS-1:0]        rd_row, rd_col;
   logic                                   req_fire;
   logic                                   change;
   logic                                   trial_flip;
   logic [ising_pkg::ENERGY_W-1:0]         energy_delta;
   logic                                   rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // neighbor addressing; 4-bit wrap gives the periodic boundary
   always_comb begin
      rd_row = row_ff;
      rd_col = col_ff;
      case (step_ff)
         3'd1:    rd_row = row_ff + 1'b1;
         3'd2:    rd_col = col_ff + 1'b1;
         3'd3:    rd_row = row_ff - 1'b1;
         3'd4:    rd_col = col_ff - 1'b1;
         default: ;
      endcase
   end

   // Metropolis decision: agree = neighbors matching the site spin.
   // agree <= 2 means cost <= 0, 3 means cost 4, 4 means cost 8.
   always_comb begin
      case (agree_ff)
         3'd3:    trial_flip = {1'b0, frac_ff} < level_four_ff;
         3'd4:    trial_flip = {1'b0, frac_ff} < level_eight_ff;
         default: trial_flip = 1'b1;
      endcase
   end

   // a change of spin moves energy by 4*agree - 8 and magnetization by 2
   assign change       = (cmd_ff == ising_pkg::CMD_TRIAL) ? trial_flip
                                                           : (spin_in_ff != center_ff);
   assign energy_delta = {6'd0, agree_ff, 2'b00} - 11'd8;

   always_comb begin
      lat_req.we    = 1'b0;
      lat_req.addr  = {rd_row, rd_col};
      lat_req.wdata = ~center_ff;
      if (state_ff == ST_EVAL) begin
         lat_req.addr = {row_ff, col_ff};
         lat_req.we   = change;
      end
   end

   ising_lattice u_lattice (
      .clock   (clock),
      .reset   (reset),
      .lat_req (lat_req),
      .rd_spin (rd_spin)
   );

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      agree_in    = agree_ff;
      center_in   = center_ff;
      energy_in   = energy_ff;
      mag_in      = mag_ff;
      flip_in     = flip_ff;
      spin_new_in = spin_new_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
               step_in  = '0;
               agree_in = '0;
            end
         end
         ST_READ: begin
            step_in = step_ff + 1'b1;
            // read data comes from the lattice's output register, so each step sees the previous step's read
            if (step_ff == 3'd1) begin
               center_in = rd_spin;
            end else if (step_ff != 3'd0) begin
               agree_in = agree_ff + {2'b00, (rd_spin == center_ff)};
            end
            if (step_ff == 3'(ising_pkg::READ_COUNT)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            flip_in     = (cmd_ff == ising_pkg::CMD_TRIAL) && trial_flip;
            spin_new_in = change ? ~center_ff : center_ff;
            if (change) begin
               energy_in = energy_ff + energy_delta;
               mag_in    = center_ff ? mag_ff - 10'd2 : mag_ff + 10'd2;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         agree_ff       <= '0;
         energy_ff      <= ising_pkg::ENERGY_RESET;
         mag_ff         <= ising_pkg::MAG_RESET;
         level_four_ff  <= ising_pkg::LEVEL_RESET;
         level_eight_ff <= ising_pkg::LEVEL_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         agree_ff  <= agree_in;
         energy_ff <= energy_in;
         mag_ff    <= mag_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ising_pkg::CSR_LEVEL_FOUR:  level_four_ff  <= csr_data;
               ising_pkg::CSR_LEVEL_EIGHT: level_eight_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      center_ff   <= center_in;
      flip_ff     <= flip_in;
      spin_new_ff <= spin_new_in;
      if (req_fire) begin
         cmd_ff     <= req_tuser;
         row_ff     <= req_tdata[3:0];
         col_ff     <= req_tdata[7:4];
         spin_in_ff <= req_tdata[8];
         frac_ff    <= req_tdata[24:9];
      end
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_data_ff <= {1'b0, mag_ff, energy_ff, spin_new_ff, flip_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/ising_checker.sv
// Checker: predicts every Ising spin update result and compares it with the block's output.
module ising_checker
   import ising_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          trial_count,
   output int          flip_count,
   output int          write_count,
   output int          energy_low,
   output int          energy_high
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic                flipped;
      logic                spin;
      logic [ENERGY_W-1:0] energy;
      logic [MAG_W-1:0]    mag;
   } spin_result_type;

   logic                spin_grid [SITES];
   logic [ENERGY_W-1:0] energy_sum;
   logic [MAG_W-1:0]    mag_sum;
   logic [LEVEL_W-1:0]  level_four;
   logic [LEVEL_W-1:0]  level_eight;
   spin_result_type     expected_q [$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      trial_count = 0;
      flip_count  = 0;
      write_count = 0;
      energy_low  = 0;
      energy_high = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic int spin_of(input logic [SIDE_BITS-1:0] row, col);
      return spin_grid[{row, col}] ? 1 : -1;
   endfunction

   // Periodic wrap falls out of the 4-bit index arithmetic.
   function automatic int neighbor_total(input logic [SIDE_BITS-1:0] row, col);
      logic [SIDE_BITS-1:0] up, down, left, right;
      up    = row - 1'b1;
      down  = row + 1'b1;
      left  = col - 1'b1;
      right = col + 1'b1;
      return spin_of(down, col) + spin_of(row, right) + spin_of(up, col) + spin_of(row, left);
   endfunction

   // Energy moves by -diff*neighbors, magnetization by diff.
   function automatic void set_site(input logic [SIDE_BITS-1:0] row, col, input int new_spin);
      int diff;
      diff       = new_spin - spin_of(row, col);
      energy_sum = energy_sum - ENERGY_W'(diff * neighbor_total(row, col));
      mag_sum    = mag_sum + MAG_W'(diff);
      spin_grid[{row, col}] = (new_spin > 0);
   endfunction

   function automatic spin_result_type predict_update(input logic cmd,
                                                      input logic [SIDE_BITS-1:0] row, col,
                                                      input logic spin_in,
                                                      input logic [FRAC_W-1:0] frac);
      spin_result_type res;
      int              s;
      int              cost;
      logic            flip;
      s    = spin_of(row, col);
      flip = 1'b0;
      if (cmd == CMD_WRITE) begin
         set_site(row, col, spin_in ? 1 : -1);
      end else begin
         cost = 2 * s * neighbor_total(row, col);
         if (cost <= 0)
            flip = 1'b1;
         else if (cost == 4)
            flip = ({1'b0, frac} < level_four);
         else
            flip = ({1'b0, frac} < level_eight);
         if (flip)
            set_site(row, col, -s);
      end
      res.flipped = flip;
      res.spin    = spin_grid[{row, col}];
      res.energy  = energy_sum;
      res.mag     = mag_sum;
      return res;
   endfunction

   always @(posedge clock) begin
      spin_result_type got;
      spin_result_type want;
      if (reset) begin
         foreach (spin_grid[i])
            spin_grid[i] = 1'b1;
         energy_sum  = ENERGY_RESET;
         mag_sum     = MAG_RESET;
         level_four  = LEVEL_RESET;
         level_eight = LEVEL_RESET;
         expected_q.delete();
         energy_low  = int'($signed(ENERGY_RESET));
         energy_high = int'($signed(ENERGY_RESET));
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LEVEL_FOUR)
               level_four = csr_data;
            else
               level_eight = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.flipped = rsp_tdata[0];
            got.spin    = rsp_tdata[1];
            got.energy  = rsp_tdata[12:2];
            got.mag     = rsp_tdata[22:13];
            if (expected_q.size() == 0) begin
               report_mismatch("result with no item pending", int'(rsp_tdata), 0);
            end else begin
               want = expected_q.pop_front();
               if (got.flipped !== want.flipped)
                  report_mismatch("flipped", int'(got.flipped), int'(want.flipped));
               if (got.spin !== want.spin)
                  report_mismatch("spin_out", int'(got.spin), int'(want.spin));
               if (got.energy !== want.energy)
                  report_mismatch("energy", int'($signed(got.energy)),
                                  int'($signed(want.energy)));
               if (got.mag !== want.mag)
                  report_mismatch("magnetization", int'($signed(got.mag)),
                                  int'($signed(want.mag)));
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_update(req_tuser, req_tdata[3:0], req_tdata[7:4], req_tdata[8],
                                  req_tdata[24:9]);
            expected_q.push_back(want);
            if (req_tuser == CMD_TRIAL) begin
               trial_count++;
               if (want.flipped)
                  flip_count++;
            end else begin
               write_count++;
            end
            if (int'($signed(want.energy)) < energy_low)
               energy_low = int'($signed(want.energy));
            if (int'($signed(want.energy)) > energy_high)
               energy_high = int'($signed(want.energy));
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> tb/testbench.sv
// Testbench top: stimulus, receiver stalls and verdict for the Ising spin update block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ising_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   // Receiver hold-off long enough to back up the response register and the input.
   localparam int LONG_STALL  = 200;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // row[3:0], col[7:4], spin_in[8], rand_fraction[24:9]
   logic        req_tuser  = CMD_WRITE;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // flipped[0], spin_out[1], energy[12:2], magnetization[22:13]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = CSR_LEVEL_FOUR;
   logic [16:0] csr_data   = '0;

   int fail_count, pending, trial_count, flip_count, write_count, energy_low, energy_high;

   // Stall control shared by sender and receiver; 0 means no idling at all.
   int idle_pct       = 0;
   bit long_stall_due = 1'b0;
   int cycle_count    = 0;
   int level_settings = 0;
   logic [LEVEL_W-1:0] cur_four  = LEVEL_RESET;
   logic [LEVEL_W-1:0] cur_eight = LEVEL_RESET;

   ising_metropolis_spin_update DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ising_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .trial_count (trial_count),
      .flip_count  (flip_count),
      .write_count (write_count),
      .energy_low  (energy_low),
      .energy_high (energy_high)
   );

   always #5 clock = ~clock;

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Receiver: random ready bursts, plus one long hold-off on request.
   initial begin : receiver
      int held;
      forever begin
         @(negedge clock);
         if (long_stall_due) begin
            long_stall_due = 1'b0;
            rsp_tready <= 1'b0;
            held = 0;
            while (held < LONG_STALL) begin
               @(negedge clock);
               held++;
            end
            rsp_tready <= 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one item; entered and left at a falling edge. Valid stays up between
   // back-to-back items so only the data changes.
   task automatic push_item(input logic cmd, input logic [SIDE_BITS-1:0] row, col,
                            input logic spin, input logic [FRAC_W-1:0] frac);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, frac, spin, col, row};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending != 0);
   endtask

   // Threshold writes happen only with the block idle.
   task automatic write_levels(input logic [LEVEL_W-1:0] four, eight);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= CSR_LEVEL_FOUR;
      csr_data  <= four;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_LEVEL_EIGHT;
      csr_data  <= eight;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_four  = four;
      cur_eight = eight;
      level_settings++;
   endtask

   // Mixed writes and trials; some fractions land right at a threshold to hit the
   // strict less-than compare from both sides.
   task automatic random_items(input int count, input int trial_pct);
      logic               cmd;
      logic [FRAC_W-1:0]  frac;
      logic [LEVEL_W-1:0] level;
      repeat (count) begin
         cmd  = ($urandom_range(0, 99) < trial_pct) ? CMD_TRIAL : CMD_WRITE;
         frac = FRAC_W'($urandom);
         if ($urandom_range(0, 4) == 0) begin
            level = $urandom_range(0, 1) ? cur_four : cur_eight;
            frac  = FRAC_W'(int'(level) + int'($urandom_range(0, 2)) - 1);
         end
         push_item(cmd, SIDE_BITS'($urandom), SIDE_BITS'($urandom), 1'($urandom), frac);
      end
   endtask

   // Whole-lattice write: checkerboard drives energy to its top, all-down to its bottom.
   task automatic fill_lattice(input bit alternate);
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++)
            push_item(CMD_WRITE, SIDE_BITS'(r), SIDE_BITS'(c),
                      alternate ? 1'((r ^ c) & 1) : 1'b0, FRAC_W'($urandom));
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 25;

      // Reset thresholds accept everything: fraction at its top still flips a cost-8 site.
      push_item(CMD_TRIAL, 4'd0, 4'd0, 1'b1, 16'hFFFF);
      push_item(CMD_TRIAL, 4'd0, 4'd0, 1'b0, 16'h0000);   // now downhill, flips back
      push_item(CMD_WRITE, 4'd15, 4'd15, 1'b0, 16'hFFFF);
      push_item(CMD_WRITE, 4'd15, 4'd15, 1'b0, 16'h0000); // same value again: no change
      push_item(CMD_TRIAL, 4'd0, 4'd15, 1'b0, 16'hFFFF);  // neighbors wrap across both edges
      push_item(CMD_TRIAL, 4'd15, 4'd0, 1'b1, 16'h3039);
      push_item(CMD_WRITE, 4'd15, 4'd15, 1'b1, 16'h5555);
      push_item(CMD_WRITE, 4'd0, 4'd15, 1'b1, 16'hAAAA);

      // Zero thresholds: uphill moves never pass, flat and downhill still flip.
      write_levels('0, '0);
      push_item(CMD_TRIAL, 4'd8, 4'd8, 1'b1, 16'h0000);   // cost eight
      push_item(CMD_WRITE, 4'd8, 4'd9, 1'b0, 16'h0000);
      push_item(CMD_TRIAL, 4'd8, 4'd8, 1'b0, 16'h0000);   // cost four
      push_item(CMD_WRITE, 4'd7, 4'd8, 1'b0, 16'h0000);
      push_item(CMD_TRIAL, 4'd8, 4'd8, 1'b1, 16'hFFFF);   // cost zero
      push_item(CMD_TRIAL, 4'd8, 4'd8, 1'b1, 16'hFFFF);

      // Thresholds above full scale: every trial flips.
      write_levels(17'h1FFFF, 17'h1FFFF);
      push_item(CMD_TRIAL, 4'd3, 4'd3, 1'b0, 16'hFFFF);
      push_item(CMD_WRITE, 4'd3, 4'd3, 1'b1, 16'h0000);
      push_item(CMD_WRITE, 4'd3, 4'd4, 1'b0, 16'h0000);
      push_item(CMD_TRIAL, 4'd3, 4'd3, 1'b0, 16'hFFFF);

      // Mid thresholds, fraction on either side of the boundary.
      write_levels(17'd32768, 17'd100);
      push_item(CMD_WRITE, 4'd3, 4'd3, 1'b1, 16'h0000);
      push_item(CMD_TRIAL, 4'd3, 4'd3, 1'b0, 16'h8000);   // equal: no flip
      push_item(CMD_TRIAL, 4'd3, 4'd3, 1'b0, 16'h7FFF);   // one below: flip
      push_item(CMD_TRIAL, 4'd10, 4'd10, 1'b0, 16'd99);
      push_item(CMD_TRIAL, 4'd11, 4'd11, 1'b0, 16'd100);

      // Random traffic with the receiver holding off long enough to back up the input.
      write_levels(LEVEL_W'($urandom_range(0, 65536)), LEVEL_W'($urandom_range(0, 65536)));
      long_stall_due = 1'b1;
      random_items(300, 70);

      // Checkerboard: energy at its top, so trials start out running downhill.
      write_levels('0, '0);
      fill_lattice(1'b1);
      random_items(100, 90);

      // All spins down, no idling on either side.
      write_levels(17'd65535, 17'd1);
      idle_pct = 0;
      fill_lattice(1'b0);
      random_items(100, 90);

      for (int phase = 0; phase < 3; phase++) begin
         write_levels(LEVEL_W'($urandom_range(0, 131071)), LEVEL_W'($urandom_range(0, 65536)));
         idle_pct = 15 + 20 * phase;
         random_items(250, 75);
      end

      // Closing stretch runs flat out.
      idle_pct = 0;
      write_levels(LEVEL_RESET, LEVEL_W'($urandom_range(0, 65536)));
      random_items(150, 75);

      drain_block();
      repeat (20) @(negedge clock);

      $display("Ran %0d items: %0d trials (%0d flipped) and %0d spin writes",
               trial_count + write_count, trial_count, flip_count, write_count);
      $display("Threshold settings: %0d; energy swept %0d to %0d; %0d mismatches",
               level_settings + 1, energy_low, energy_high, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
